@@ src/fixed_point_to_decimal_text_macros.svh @@
// assertion macros used by the rtl file fpdt_back
`ifndef FIXED_POINT_TO_DECIMAL_TEXT_MACROS_SVH
`define FIXED_POINT_TO_DECIMAL_TEXT_MACROS_SVH

`ifndef SYNTH
// pre holds in a cycle -> post holds in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// pre holds in a cycle -> post holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

@@ src/fpdt_pkg.sv @@
package fpdt_pkg;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_POINT = 7'h2E;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_SPACE = 7'h20;

    localparam logic [3:0] INT_WIDTH_MAX   = 4'd10;
    localparam logic [3:0] MAX_FRAC_DIGITS = 4'd9;

    // index of the last double-dabble pass, 16 passes of two bits cover 32 bits
    localparam logic [3:0] CONV_LAST_STEP = 4'd15;

    // one converted number waiting for the text serializer
    typedef struct packed {
        logic [39:0] int_bcd;   // ten bcd digits, least significant lowest
        logic [35:0] frac_bcd;  // nine bcd digits
        logic        neg;
        logic [3:0]  pad;       // leading spaces
        logic [3:0]  size;      // integer digits, 1..10
        logic [3:0]  fdig;      // fraction digits, 0..9
        logic        ovf;
    } fpdt_entry_t;

    function automatic logic [29:0] pow10(input logic [3:0] n);
        logic [29:0] r;
        unique case (n)
            4'd0:    r = 30'd1;
            4'd1:    r = 30'd10;
            4'd2:    r = 30'd100;
            4'd3:    r = 30'd1000;
            4'd4:    r = 30'd10000;
            4'd5:    r = 30'd100000;
            4'd6:    r = 30'd1000000;
            4'd7:    r = 30'd10000000;
            4'd8:    r = 30'd100000000;
            4'd9:    r = 30'd1000000000;
            default: r = 30'd1;
        endcase
        return r;
    endfunction

    // one double-dabble step: add 3 to digits >= 5, then shift in a bit
    function automatic logic [39:0] dd_step(input logic [39:0] bcd, input logic b);
        logic [39:0] adj;
        for (int i = 0; i < 10; i++) begin
            adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? (bcd[i*4 +: 4] + 4'd3)
                                                    : bcd[i*4 +: 4];
        end
        return {adj[38:0], b};
    endfunction

endpackage

@@ src/fpdt_queue.sv @@
module fpdt_queue
    import fpdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        push_ready,
    input  fpdt_entry_t push_data,
    output logic        pop_valid,
    input  logic        pop_ready,
    output fpdt_entry_t pop_data
);

    fpdt_entry_t slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        do_push;
    logic        do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/fpdt_front.sv @@
module fpdt_front
    import fpdt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] value,
    input  logic signed [5:0]  binary_exponent,
    input  logic [3:0]         int_width,
    input  logic [3:0]         frac_digits,
    output logic               push_valid,
    input  logic               push_ready,
    output fpdt_entry_t        push_data
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_SHIFT = 5'b00100,
        ST_CONV  = 5'b01000,
        ST_PUSH  = 5'b10000
    } front_state_t;

    front_state_t state_reg, state_next;

    logic        neg_reg;
    logic        shr_reg;
    logic [5:0]  sh_reg;
    logic        ovf_reg;
    logic [3:0]  width_reg;
    logic [3:0]  fdig_reg;
    logic [31:0] ibin_reg;
    logic [31:0] fbin_reg;
    logic [61:0] prod_reg;
    logic [39:0] ibcd_reg;
    logic [39:0] fbcd_reg;
    logic [3:0]  step_reg;

    logic [31:0] value_u;
    logic [5:0]  exp_u;
    logic [31:0] mag_c;
    logic        shr_c;
    logic [5:0]  sh_c;
    logic [32:0] mag33_c;
    logic [32:0] rmask_c;
    logic [62:0] lsh_c;
    logic [31:0] ipart_c;
    logic [31:0] rem_c;
    logic        ovf_sh_c;
    logic [61:0] frac_wide_c;
    logic [3:0]  size_c;
    logic [3:0]  need_c;
    logic        accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // magnitude and binary point split
    always_comb
    begin
        value_u  = value;
        exp_u    = binary_exponent;
        mag_c    = value_u[31] ? (~value_u + 32'd1) : value_u;
        shr_c    = exp_u[5];
        sh_c     = shr_c ? 6'(7'd64 - {1'b0, exp_u}) : exp_u;
        mag33_c  = {1'b0, mag_c};
        rmask_c  = (33'd1 << sh_c) - 33'd1;
        lsh_c    = {31'd0, mag_c} << sh_c[4:0];
        ipart_c  = shr_c ? 32'(mag33_c >> sh_c) : lsh_c[31:0];
        rem_c    = shr_c ? 32'(mag33_c & rmask_c) : 32'd0;
        ovf_sh_c = !shr_c && (lsh_c[62:32] != 31'd0);
    end

    assign frac_wide_c = shr_reg ? (prod_reg >> sh_reg) : 62'd0;

    // integer digit count from the bcd result
    always_comb
    begin
        size_c = 4'd1;
        for (int i = 1; i < 10; i++)
        begin
            if (ibcd_reg[i*4 +: 4] != 4'd0)
            begin
                size_c = 4'(i + 1);
            end
        end
        need_c = size_c + {3'd0, neg_reg};
    end

    assign push_valid         = (state_reg == ST_PUSH);
    assign push_data.int_bcd  = ibcd_reg;
    assign push_data.frac_bcd = fbcd_reg[35:0];
    assign push_data.neg      = neg_reg;
    assign push_data.pad      = (width_reg > need_c) ? (width_reg - need_c) : 4'd0;
    assign push_data.size     = size_c;
    assign push_data.fdig     = fdig_reg;
    assign push_data.ovf      = ovf_reg || (need_c > width_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_MUL;
            ST_MUL:   state_next = ST_SHIFT;
            ST_SHIFT: state_next = ST_CONV;
            ST_CONV:  if (step_reg == CONV_LAST_STEP) state_next = ST_PUSH;
            ST_PUSH:  if (push_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CONV)
            begin
                step_reg <= step_reg + 4'd1;
            end
            else
            begin
                step_reg <= 4'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_reg   <= value_u[31];
                    shr_reg   <= shr_c;
                    sh_reg    <= sh_c;
                    ovf_reg   <= ovf_sh_c;
                    width_reg <= (int_width > INT_WIDTH_MAX) ? INT_WIDTH_MAX : int_width;
                    fdig_reg  <= (frac_digits > MAX_FRAC_DIGITS) ? MAX_FRAC_DIGITS
                                                                 : frac_digits;
                    ibin_reg  <= ipart_c;
                    fbin_reg  <= rem_c;
                end
            end
            ST_MUL:
            begin
                prod_reg <= fbin_reg * pow10(fdig_reg);
            end
            ST_SHIFT:
            begin
                fbin_reg <= {2'd0, frac_wide_c[29:0]};
                ibcd_reg <= 40'd0;
                fbcd_reg <= 40'd0;
            end
            ST_CONV:
            begin
                ibcd_reg <= dd_step(dd_step(ibcd_reg, ibin_reg[31]), ibin_reg[30]);
                fbcd_reg <= dd_step(dd_step(fbcd_reg, fbin_reg[31]), fbin_reg[30]);
                ibin_reg <= {ibin_reg[29:0], 2'd0};
                fbin_reg <= {fbin_reg[29:0], 2'd0};
            end
            ST_PUSH:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ src/fpdt_back.sv @@
`include "fixed_point_to_decimal_text_macros.svh"

module fpdt_back
    import fpdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  fpdt_entry_t pop_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  character,
    output logic        last,
    output logic        width_overflow
);

    typedef enum logic [4:0] {
        PH_PAD   = 5'b00001,
        PH_SIGN  = 5'b00010,
        PH_INT   = 5'b00100,
        PH_POINT = 5'b01000,
        PH_FRAC  = 5'b10000
    } back_phase_t;

    back_phase_t phase_reg, phase_next;
    logic        busy_reg, busy_next;
    logic [3:0]  cnt_reg, cnt_next;
    fpdt_entry_t entry_reg, entry_next;
    logic        out_valid_reg, out_valid_next;
    logic [6:0]  char_reg, char_next;
    logic        last_reg, last_next;
    logic        ovf_reg, ovf_next;

    logic        emit;
    logic        last_c;
    logic [6:0]  char_c;
    logic [3:0]  idx_c;
    logic [3:0]  int_dig [10];
    logic [3:0]  frac_dig [9];

    always_comb
    begin
        for (int i = 0; i < 10; i++)
        begin
            int_dig[i] = entry_reg.int_bcd[i*4 +: 4];
        end
        for (int i = 0; i < 9; i++)
        begin
            frac_dig[i] = entry_reg.frac_bcd[i*4 +: 4];
        end
    end

    assign idx_c     = cnt_reg - 4'd1;
    assign pop_ready = !busy_reg;
    assign emit      = busy_reg && (!out_valid_reg || out_ready);

    assign out_valid      = out_valid_reg;
    assign character      = char_reg;
    assign last           = last_reg;
    assign width_overflow = ovf_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        entry_next     = entry_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        ovf_next       = ovf_reg;
        char_c         = CH_SPACE;
        last_c         = 1'b0;

        if (!busy_reg && pop_valid)
        begin
            entry_next = pop_data;
            busy_next  = 1'b1;
            if (pop_data.pad != 4'd0)
            begin
                phase_next = PH_PAD;
                cnt_next   = pop_data.pad;
            end
            else if (pop_data.neg)
            begin
                phase_next = PH_SIGN;
            end
            else
            begin
                phase_next = PH_INT;
                cnt_next   = pop_data.size;
            end
        end

        unique case (phase_reg)
            PH_PAD:
            begin
                char_c = CH_SPACE;
                if (emit)
                begin
                    if (cnt_reg == 4'd1)
                    begin
                        phase_next = entry_reg.neg ? PH_SIGN : PH_INT;
                        cnt_next   = entry_reg.size;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 4'd1;
                    end
                end
            end
            PH_SIGN:
            begin
                char_c = CH_MINUS;
                if (emit)
                begin
                    phase_next = PH_INT;
                    cnt_next   = entry_reg.size;
                end
            end
            PH_INT:
            begin
                char_c = CH_ZERO + {3'd0, int_dig[idx_c]};
                last_c = (cnt_reg == 4'd1) && (entry_reg.fdig == 4'd0);
                if (emit)
                begin
                    if (cnt_reg == 4'd1)
                    begin
                        phase_next = PH_POINT;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 4'd1;
                    end
                end
            end
            PH_POINT:
            begin
                char_c = CH_POINT;
                if (emit)
                begin
                    phase_next = PH_FRAC;
                    cnt_next   = entry_reg.fdig;
                end
            end
            PH_FRAC:
            begin
                char_c = CH_ZERO + {3'd0, frac_dig[idx_c]};
                last_c = (cnt_reg == 4'd1);
                if (emit && cnt_reg != 4'd1)
                begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            default:
            begin
                char_c = CH_SPACE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
            char_next      = char_c;
            last_next      = last_c;
            ovf_next       = entry_reg.ovf;
            if (last_c)
            begin
                busy_next = 1'b0;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PAD;
            busy_reg      <= 1'b0;
            cnt_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        ovf_reg   <= ovf_next;
    end

    `ASSERT_IMPLY(a_cnt_nonzero, clk, rst_n, busy_reg && (phase_reg == PH_PAD || phase_reg == PH_INT || phase_reg == PH_FRAC), cnt_reg != 4'd0)
    `ASSERT_NEXT(a_last_frees, clk, rst_n, emit && last_c, !busy_reg)
    `ASSERT_IMPLY(a_point_has_frac, clk, rst_n, busy_reg && phase_reg == PH_POINT, entry_reg.fdig != 4'd0)

endmodule

@@ src/fixed_point_to_decimal_text.sv @@
// the front converts one number at a time (one 32x30 multiply,
// 16 two-bit double-dabble passes); the back then emits its n characters,
// with n up to 21 characters per number
// reset: rst_n is asynchronous and active low, clears all control state
module fixed_point_to_decimal_text
    import fpdt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] value,
    input  logic signed [5:0]  binary_exponent,
    input  logic [3:0]         int_width,
    input  logic [3:0]         frac_digits,
    // output channel, one character per transaction
    output logic               out_valid,
    input  logic               out_ready,
    output logic [6:0]         character,
    output logic               last,
    output logic               width_overflow
);

    // converted numbers travel from the front to the back as one entry
    fpdt_entry_t push_data;
    fpdt_entry_t pop_data;
    logic        push_valid;
    logic        push_ready;
    logic        pop_valid;
    logic        pop_ready;

    // front: takes the magnitude, splits integer and fraction at the binary
    // point, scales the fraction remainder by a power of ten, then runs the
    // integer and fraction through two parallel double-dabble converters.
    // it also sizes the integer, works out padding and the overflow flag
    fpdt_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .value           (value),
        .binary_exponent (binary_exponent),
        .int_width       (int_width),
        .frac_digits     (frac_digits),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_data       (push_data)
    );

    // two-entry queue so the front can start the next number while the
    // back is still streaming text
    fpdt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // back: walks padding, sign, integer digits, point and fraction digits,
    // one character per cycle unless out_ready holds it, into a registered output stage
    fpdt_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_data       (pop_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .character      (character),
        .last           (last),
        .width_overflow (width_overflow)
    );

endmodule

@@ verif/tb_fixed_point_to_decimal_text.sv @@
module tb_fixed_point_to_decimal_text;
    timeunit 1ns;
    timeprecision 1ps;

    import fpdt_pkg::*;

    // one number waiting to be offered on the input channel
    typedef struct {
        logic [31:0] value;
        logic [5:0]  bexp;
        logic [3:0]  iw;
        logic [3:0]  fd;
        int          gap;      // idle cycles before the transaction is offered
        bit          drain;    // hold the number back until all text has come out
    } number_t;

    // one character expected on the output channel
    typedef struct {
        logic [6:0] ch;
        logic       last;
        logic       ovf;
    } text_char_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                in_valid = 1'b0;
    logic                in_ready;
    logic signed [31:0]  value = '0;
    logic signed [5:0]   binary_exponent = '0;
    logic [3:0]          int_width = '0;
    logic [3:0]          frac_digits = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [6:0]          character;
    logic                last;
    logic                width_overflow;

    number_t    numbers_to_send[$];
    text_char_t expected_text[$];

    // handshakes seen at the last rising edge, used by the falling-edge drivers
    logic in_took = 1'b0;
    logic out_took = 1'b0;

    int total_numbers = 0;
    int numbers_taken = 0;
    int chars_checked = 0;
    int flagged_numbers = 0;
    int negative_numbers = 0;
    int errors = 0;

    fixed_point_to_decimal_text dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .value          (value),
        .binary_exponent(binary_exponent),
        .int_width      (int_width),
        .frac_digits    (frac_digits),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .character      (character),
        .last           (last),
        .width_overflow (width_overflow)
    );

    always #6 clk = ~clk;

    // expected text of one number, appended to expected_text; returns the overflow flag
    function automatic bit render_number(input logic [31:0] raw, input logic [5:0] e,
                                         input logic [3:0] w_in, input logic [3:0] f_in);
        logic        neg;
        logic        ovf;
        logic [31:0] mag;
        logic [31:0] ipart;
        logic [63:0] wide;
        logic [63:0] ipw;
        logic [63:0] rem;
        logic [63:0] frac;
        logic [63:0] scale;
        logic [3:0]  idig[10];
        logic [3:0]  fdig_val[9];
        logic [6:0]  chars[$];
        int          sh;
        int          width;
        int          fdig;
        int          size;
        int          need;
        int          i;
        text_char_t  tc;

        neg = raw[31];
        mag = neg ? (~raw + 32'd1) : raw;
        ovf = 1'b0;
        width = (w_in > INT_WIDTH_MAX) ? int'(INT_WIDTH_MAX) : int'(w_in);
        fdig = (f_in > MAX_FRAC_DIGITS) ? int'(MAX_FRAC_DIGITS) : int'(f_in);
        scale = 64'd1;
        for (i = 0; i < fdig; i++)
            scale = scale * 64'd10;

        if (e[5]) begin
            // negative exponent: right shift by 1..32, low bits become the fraction
            sh = 64 - int'(e);
            wide = {32'd0, mag};
            ipw = wide >> sh;
            rem = wide - (ipw << sh);
            ipart = ipw[31:0];
            frac = (rem * scale) >> sh;
        end
        else begin
            // left shift keeps the low 32 bits, anything above is lost
            sh = int'(e);
            wide = {32'd0, mag} << sh;
            ovf = (wide[63:32] != 32'd0);
            ipart = wide[31:0];
            frac = 64'd0;
        end

        size = 0;
        do begin
            idig[size] = 4'(ipart % 32'd10);
            ipart = ipart / 32'd10;
            size++;
        end while (ipart != 32'd0);

        need = size + (neg ? 1 : 0);
        if (need > width)
            ovf = 1'b1;

        for (i = need; i < width; i++)
            chars.push_back(CH_SPACE);
        if (neg)
            chars.push_back(CH_MINUS);
        for (i = size - 1; i >= 0; i--)
            chars.push_back(CH_ZERO + 7'(idig[i]));
        if (fdig > 0) begin
            chars.push_back(CH_POINT);
            for (i = fdig - 1; i >= 0; i--) begin
                fdig_val[i] = 4'(frac % 64'd10);
                frac = frac / 64'd10;
            end
            for (i = 0; i < fdig; i++)
                chars.push_back(CH_ZERO + 7'(fdig_val[i]));
        end

        for (i = 0; i < chars.size(); i++) begin
            tc.ch = chars[i];
            tc.last = (i == chars.size() - 1);
            tc.ovf = ovf;
            expected_text.push_back(tc);
        end
        return ovf;
    endfunction

    function automatic void queue_number(input logic [31:0] v, input int e, input int w,
                                         input int f, input int gap, input bit drain);
        number_t n;
        n.value = v;
        n.bexp = 6'(e);
        n.iw = 4'(w);
        n.fd = 4'(f);
        n.gap = gap;
        n.drain = drain;
        numbers_to_send.push_back(n);
        total_numbers++;
    endfunction

    // random value spread over full range, small magnitudes and the extremes
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        int          sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            v = $urandom;
        else if (sel < 6)
            v = 32'($urandom_range(0, 2000));
        else if (sel == 6) begin
            case ($urandom_range(0, 4))
                0: v = 32'h8000_0000;
                1: v = 32'h7fff_ffff;
                2: v = 32'h0000_0000;
                3: v = 32'hffff_ffff;
                default: v = 32'h0000_0001;
            endcase
        end
        else
            v = $urandom >> $urandom_range(0, 31);
        if (sel >= 4 && sel != 6 && $urandom_range(0, 1))
            v = ~v + 32'd1;
        return v;
    endfunction

    // stimulus, reset, and end of run
    initial begin
        int i;
        int mode;
        int gap;
        int e;
        int w;
        int f;

        // directed corners: zero, extremes, negative zero, both overflow kinds,
        // out-of-range width and fraction count, exponent of minus thirty-two
        queue_number(32'd0,          0,   1,  0, 0, 0);
        queue_number(32'd0,          0,  10,  9, 0, 0);
        queue_number(32'h7fff_ffff,  0,  10,  0, 0, 0);
        queue_number(32'h8000_0000,  0,  10,  3, 0, 0);
        queue_number(32'h8000_0000, -32,  3,  9, 0, 0);
        queue_number(32'd1,          31, 10,  0, 3, 0);
        queue_number(32'd3,          31, 10,  2, 0, 0);
        queue_number(32'hffff_ffff, -4,   4,  4, 0, 0);
        queue_number(32'h7fff_ffff, -31,  2,  9, 0, 0);
        queue_number(32'd123,        5,   0,  0, 5, 0);
        queue_number(32'd5,          0,  15,  1, 0, 0);
        queue_number(32'd1,         -1,   2, 15, 0, 0);
        queue_number(32'h8000_0001,  31, 10,  9, 0, 0);
        queue_number(32'd255,       -8,   3,  1, 0, 0);
        queue_number(32'd1000000000, 0,   4,  0, 0, 0);
        queue_number(32'hffff_fffb,  0,   2,  0, 0, 0);
        queue_number(32'hffff_fffb,  0,   1,  0, 0, 0);
        queue_number(32'hffff_ffff,  0,   3,  2, 0, 0);
        queue_number(32'd1,         -32,  1,  9, 0, 0);
        queue_number(32'h1234_5678, -16,  6,  5, 2, 0);
        queue_number(32'd1,          31, 10,  9, 0, 0);
        queue_number(32'hffff_ffff,  0,   0,  0, 0, 0);
        queue_number(32'hffff_ffff, -32, 15, 12, 0, 0);
        queue_number(32'd999999999,  1,  10,  9, 0, 0);

        // random part, sender idling changes character every forty numbers
        for (i = 0; i < 346; i++) begin
            if (i % 40 == 0)
                mode = $urandom_range(0, 2);
            gap = (mode == 0) ? 0 : $urandom_range(0, 18);
            if ($urandom_range(0, 9) < 6)
                e = $urandom_range(0, 63) - 32;
            else
                e = $urandom_range(0, 28) - 24;
            w = ($urandom_range(0, 19) < 17) ? $urandom_range(1, 10) : $urandom_range(0, 15);
            f = ($urandom_range(0, 19) < 17) ? $urandom_range(0, 9) : $urandom_range(10, 15);
            queue_number(pick_value(), e, w, f, gap, (i == 0 || i == 30 || i == 300));
        end

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        while (!(numbers_taken == total_numbers && expected_text.size() == 0))
            @(posedge clk);
        // anything the block still emits now is caught as unexpected
        repeat (60) @(posedge clk);
        if (expected_text.size() != 0) begin
            $error("%0d characters never arrived", expected_text.size());
            errors++;
        end

        $display("run covered %0d numbers (%0d negative, %0d with overflow flag)",
                 numbers_taken, negative_numbers, flagged_numbers);
        $display("%0d characters compared, %0d mismatches", chars_checked, errors);
        if (errors == 0)
            $display("tb_fixed_point_to_decimal_text: clean");
        else
            $display("tb_fixed_point_to_decimal_text: errors");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("tb_fixed_point_to_decimal_text: errors");
        $finish;
    end

    // input driver: offers the next number after its gap, holds it until taken
    number_t cur_number;
    bit      have_number = 1'b0;
    int      gap_left = 0;

    always @(negedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_took) begin
                // transaction still pending, payload stays put
            end
            else begin
                if (!have_number && numbers_to_send.size() > 0) begin
                    cur_number = numbers_to_send.pop_front();
                    have_number = 1'b1;
                    gap_left = cur_number.gap;
                end
                if (have_number && gap_left == 0 &&
                    !(cur_number.drain && expected_text.size() != 0)) begin
                    value           <= cur_number.value;
                    binary_exponent <= cur_number.bexp;
                    int_width       <= cur_number.iw;
                    frac_digits     <= cur_number.fd;
                    in_valid        <= 1'b1;
                    have_number = 1'b0;
                end
                else begin
                    in_valid <= 1'b0;
                    if (have_number && gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    // output receiver: random stall after each character, with two long
    // hold-offs so the block backs up and stops taking numbers
    int rx_stall = 0;
    int rx_seen = 0;
    int rx_mode = 1;

    always @(negedge clk) begin
        if (rst_n) begin
            if (out_took) begin
                rx_seen++;
                if (rx_seen % 100 == 0)
                    rx_mode = $urandom_range(0, 2);
                if (rx_seen == 1200 || rx_seen == 4000)
                    rx_stall = 400;
                else
                    rx_stall = (rx_mode == 0) ? 0 : $urandom_range(0, 18);
            end
            if (rx_stall > 0) begin
                out_ready <= 1'b0;
                rx_stall--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // monitor: predicts text on every accepted number, checks every character
    text_char_t want;

    always @(posedge clk) begin
        in_took  <= in_valid && in_ready;
        out_took <= out_valid && out_ready;
        if (rst_n && in_valid && in_ready) begin
            numbers_taken++;
            if (value[31])
                negative_numbers++;
            if (render_number(value, binary_exponent, int_width, frac_digits))
                flagged_numbers++;
        end
        if (rst_n && out_valid && out_ready) begin
            if (expected_text.size() == 0) begin
                $error("unexpected character transaction 0x%02h", character);
                errors++;
            end
            else begin
                want = expected_text.pop_front();
                chars_checked++;
                if (character !== want.ch) begin
                    $error("character: expected 0x%02h, got 0x%02h", want.ch, character);
                    errors++;
                end
                if (last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, last);
                    errors++;
                end
                if (width_overflow !== want.ovf) begin
                    $error("width_overflow: expected %0b, got %0b", want.ovf,
                           width_overflow);
                    errors++;
                end
            end
        end
    end

endmodule
